FILE: rtl/cfd_pkg.sv
// Shared types, constants and the byte-wide CRC-32 update for the frame deframer.
// No dependencies; every other file refers to it by scoped names.
package cfd_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;

    localparam logic [7:0] SYNC_RESET = 8'hA5;
    localparam logic [23:0] TIMEOUT_RESET = 24'd500000;
    localparam logic [23:0] TICK_MAX = 24'hFFFFFF;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    typedef enum logic [5:0] {
        PH_HUNT = 6'b000001,
        PH_CMD  = 6'b000010,
        PH_LEN0 = 6'b000100,
        PH_LEN1 = 6'b001000,
        PH_DATA = 6'b010000,
        PH_CRC  = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD_CRC = 2'd2,
        KIND_BAD_LEN = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [9:0]  payload_index;
        logic [7:0]  command_code;
        logic [15:0] frame_length;
    } t_result;

    // Reflected CRC-32, one byte per call.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/cfd_if.sv
// Valid/ready channel interfaces for the frame deframer: input items, results, config writes.
// Depends on cfd_pkg for the config port widths.
interface cfd_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;
    modport source(output valid, output mode, output rx_byte, input ready);
    modport sink(input valid, input mode, input rx_byte, output ready);
endinterface

interface cfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_index;
    logic [7:0]  command_code;
    logic [15:0] frame_length;
    modport source(output valid, output kind, output payload_byte, output payload_index,
                   output command_code, output frame_length, input ready);
    modport sink(input valid, input kind, input payload_byte, input payload_index,
                 input command_code, input frame_length, output ready);
endinterface

interface cfd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [cfd_pkg::CFG_IDX_W-1:0]  index;
    logic [cfd_pkg::CFG_DATA_W-1:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

FILE: rtl/cfd_parser.sv
// Frame parser: sync hunt, header, payload and CRC check state machine plus tick timeout.
// Depends on cfd_pkg (phase codes, result type, CRC update).
module cfd_parser #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_mode,
    input  logic [7:0]         i_rx_byte,
    input  logic [7:0]         i_sync_value,
    input  logic [23:0]        i_timeout_ticks,
    output logic               o_res_valid,
    output cfd_pkg::t_result   o_res
);

    localparam int POS_W = ((MAX_PAYLOAD + 1) > 4) ? $clog2(MAX_PAYLOAD + 1) : 2;
    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

    cfd_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_cmd, n_cmd;
    logic [15:0]      r_len, n_len;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [31:0]      r_crc, n_crc;
    logic [31:0]      r_rcv, n_rcv;
    logic [23:0]      r_idle, n_idle;

    logic [31:0]      crc_upd;
    logic [POS_W-1:0] pos_inc;
    logic [15:0]      len_full;
    logic [15:0]      pos_ext;
    logic [31:0]      rcv_shift;
    logic [23:0]      idle_inc;

    assign crc_upd   = cfd_pkg::crc_byte(r_crc, i_rx_byte);
    assign pos_inc   = r_pos + POS_W'(1);
    assign len_full  = {i_rx_byte, r_len[7:0]};
    assign pos_ext   = 16'(r_pos);
    assign rcv_shift = {i_rx_byte, r_rcv[31:8]};
    assign idle_inc  = (r_idle < cfd_pkg::TICK_MAX) ? r_idle + 24'd1 : r_idle;

    always_comb begin
        n_phase     = r_phase;
        n_cmd       = r_cmd;
        n_len       = r_len;
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_rcv       = r_rcv;
        n_idle      = r_idle;
        o_res_valid = 1'b0;
        o_res.kind          = cfd_pkg::KIND_DATA;
        o_res.payload_byte  = 8'd0;
        o_res.payload_index = 10'd0;
        o_res.command_code  = r_cmd;
        o_res.frame_length  = r_len;

        if (i_valid) begin
            if (i_mode) begin
                // tick: only counts inside a frame
                if (r_phase != cfd_pkg::PH_HUNT) begin
                    n_idle = idle_inc;
                    if (idle_inc > i_timeout_ticks) begin
                        n_phase = cfd_pkg::PH_HUNT;
                        n_idle  = 24'd0;
                    end
                end
            end else begin
                n_idle = 24'd0;
                case (r_phase)
                    cfd_pkg::PH_CMD: begin
                        n_cmd   = i_rx_byte;
                        n_crc   = crc_upd;
                        n_phase = cfd_pkg::PH_LEN0;
                    end
                    cfd_pkg::PH_LEN0: begin
                        n_len   = {8'd0, i_rx_byte};
                        n_crc   = crc_upd;
                        n_phase = cfd_pkg::PH_LEN1;
                    end
                    cfd_pkg::PH_LEN1: begin
                        n_len = len_full;
                        n_crc = crc_upd;
                        n_pos = '0;
                        if (len_full > MAX_LEN) begin
                            n_phase            = cfd_pkg::PH_HUNT;
                            o_res_valid        = 1'b1;
                            o_res.kind         = cfd_pkg::KIND_BAD_LEN;
                            o_res.frame_length = len_full;
                        end else if (len_full != 16'd0) begin
                            n_phase = cfd_pkg::PH_DATA;
                        end else begin
                            n_phase = cfd_pkg::PH_CRC;
                        end
                    end
                    cfd_pkg::PH_DATA: begin
                        n_crc = crc_upd;
                        n_pos = pos_inc;
                        if (16'(pos_inc) >= r_len) begin
                            n_pos   = '0;
                            n_phase = cfd_pkg::PH_CRC;
                        end
                        o_res_valid         = 1'b1;
                        o_res.kind          = cfd_pkg::KIND_DATA;
                        o_res.payload_byte  = i_rx_byte;
                        o_res.payload_index = pos_ext[9:0];
                    end
                    cfd_pkg::PH_CRC: begin
                        // CRC arrives LSB first; four shifts fill the whole word
                        n_rcv = rcv_shift;
                        n_pos = pos_inc;
                        if (r_pos[1:0] == 2'd3) begin
                            n_pos       = '0;
                            n_phase     = cfd_pkg::PH_HUNT;
                            o_res_valid = 1'b1;
                            o_res.kind  = ((~r_crc) == rcv_shift) ? cfd_pkg::KIND_GOOD
                                                                  : cfd_pkg::KIND_BAD_CRC;
                        end
                    end
                    default: begin
                        // hunting, and any stray phase code
                        n_phase = cfd_pkg::PH_HUNT;
                        if (i_rx_byte == i_sync_value) begin
                            n_crc   = cfd_pkg::CRC_INIT;
                            n_phase = cfd_pkg::PH_CMD;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= cfd_pkg::PH_HUNT;
            r_pos   <= '0;
            r_idle  <= 24'd0;
            r_crc   <= cfd_pkg::CRC_INIT;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_idle  <= n_idle;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_len <= n_len;
        r_rcv <= n_rcv;
    end

endmodule

FILE: rtl/cfd_out_buf.sv
// Two-entry result queue that decouples the parser from output backpressure.
// Depends on cfd_pkg for the result type.
module cfd_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cfd_pkg::t_result i_res,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output cfd_pkg::t_result o_res
);

    cfd_pkg::t_result r_mem [2];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_res   = r_mem[r_rd];

    always_comb begin
        n_wr    = i_push ? ~r_wr : r_wr;
        n_rd    = pop ? ~r_rd : r_rd;
        n_count = r_count + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

endmodule

FILE: rtl/crc_checked_frame_deframer.sv
// Top level of the CRC-checked frame deframer: config registers, parser and result queue.
// Depends on cfd_pkg, the channel interfaces in cfd_if.sv, cfd_parser and cfd_out_buf.
//
// Usage: i_in carries one item per transfer, a received byte (mode 0) or a time tick
// (mode 1). The block hunts for the sync byte, then takes command, 16-bit length (LE),
// payload and a 32-bit CRC (LE). Each payload byte yields one result; the frame end
// yields "good" or "bad CRC", and an oversize length yields "bad length" right away.
// i_cfg writes sync_value (index 0) or timeout_ticks (index 1); it is always ready and
// should be written only while the block is idle. Other indexes are ignored.
// Each result is registered in the result queue before it is presented on o_out.
// Throughput: one input item per cycle while the result queue has space; the CRC is updated a full byte per cycle.
// The two-entry result queue keeps i_in ready while one result is waiting, so a
// stalled receiver backs up the input only once both entries are full.
// Reset (synchronous, active low) puts the parser in sync hunt, empties the queue and
// restores sync 0xA5 and timeout 500000 ticks.
module crc_checked_frame_deframer #(
    parameter int MAX_PAYLOAD = 1024
) (
    input logic i_clk,
    input logic i_rst_n,
    cfd_in_if.sink    i_in,
    cfd_cfg_if.sink   i_cfg,
    cfd_out_if.source o_out
);

    logic [7:0]  r_sync_value;
    logic [23:0] r_timeout_ticks;

    logic             in_xfer;
    logic             res_valid;
    logic             space;
    cfd_pkg::t_result res;
    cfd_pkg::t_result out_res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value    <= cfd_pkg::SYNC_RESET;
            r_timeout_ticks <= cfd_pkg::TIMEOUT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                cfd_pkg::CFG_SYNC_VALUE:    r_sync_value    <= i_cfg.data[7:0];
                cfd_pkg::CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign i_in.ready = space;
    assign in_xfer    = i_in.valid && space;

    cfd_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (in_xfer),
        .i_mode          (i_in.mode),
        .i_rx_byte       (i_in.rx_byte),
        .i_sync_value    (r_sync_value),
        .i_timeout_ticks (r_timeout_ticks),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    cfd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_space (space),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (out_res)
    );

    assign o_out.kind          = out_res.kind;
    assign o_out.payload_byte  = out_res.payload_byte;
    assign o_out.payload_index = out_res.payload_index;
    assign o_out.command_code  = out_res.command_code;
    assign o_out.frame_length  = out_res.frame_length;

endmodule
